>>> rtl/set_assoc_hash_table_probe_defines.svh
// Assertion macros for the set-associative hash table probe.
// Included by the top level; no dependencies. Define SYNTH to drop the checks.
`ifndef SET_ASSOC_HASH_TABLE_PROBE_DEFINES_SVH
`define SET_ASSOC_HASH_TABLE_PROBE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SHTP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shtp check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SHTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shtp check failed");
`else
`define SHTP_ASSERT_SAME(lbl, ante, cons)
`define SHTP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/shtp_pkg.sv
// Shared types and constants for the set-associative hash table probe.
// No dependencies; used by shtp_ctrl, shtp_dp and the top level.
package shtp_pkg;

  localparam int WAYS_DEF     = 4;
  localparam int CLUSTERS_DEF = 1024;
  localparam int SAMPLE_TOTAL = 1000;

  localparam int KEY_W       = 64;
  localparam int TAG_W       = 32;
  localparam int DEPTH_W     = 16;
  localparam int GEN_W       = 8;
  localparam int PAYLOAD_W   = 32;
  localparam int CMD_W       = 2;
  localparam int WAY_FIELD_W = 2;
  localparam int COUNT_W     = 10;

  localparam int APB_AW = 2;
  localparam int APB_DW = 32;

  localparam logic [APB_AW-1:0] ADDR_GEN = 2'd0;

  localparam logic [CMD_W-1:0] CMD_PROBE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [DEPTH_W-1:0] depth;
    logic [GEN_W-1:0]        gen;
    logic [PAYLOAD_W-1:0]    payload;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic eval;
    logic scan_run;
    logic scan_emit;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic scan_done;
  } sts_t;

endpackage

>>> rtl/shtp_ctrl.sv
// Sequencer for the hash table probe: clearing pass, item capture, evaluate, fullness scan.
// Depends on shtp_pkg.
module shtp_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [shtp_pkg::CMD_W-1:0]    in_command,
  input  shtp_pkg::sts_t                sts,
  output shtp_pkg::ctl_t                ctl,
  output logic                          busy
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_command == shtp_pkg::CMD_COUNT) ? S_SCAN : S_EVAL;
        end
      end
      S_EVAL:  state_nxt = S_IDLE;
      S_SCAN:  if (sts.scan_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.clear_step = (state_r == S_CLEAR);
    ctl.capture    = (state_r == S_IDLE) && start;
    ctl.eval       = (state_r == S_EVAL);
    ctl.scan_run   = (state_r == S_SCAN);
    ctl.scan_emit  = (state_r == S_SCAN) && sts.scan_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

>>> rtl/shtp_dp.sv
// Datapath for the hash table probe: cluster memory, way compare, replacement pick,
// fullness accumulator and result register. Depends on shtp_pkg.
module shtp_dp #(
  parameter int WAYS     = shtp_pkg::WAYS_DEF,
  parameter int CLUSTERS = shtp_pkg::CLUSTERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  shtp_pkg::ctl_t                      ctl,
  output shtp_pkg::sts_t                      sts,
  input  logic [shtp_pkg::GEN_W-1:0]          gen,
  input  logic [shtp_pkg::CMD_W-1:0]          in_command,
  input  logic [shtp_pkg::KEY_W-1:0]          in_key,
  input  logic [shtp_pkg::WAY_FIELD_W-1:0]    in_write_way,
  input  logic signed [shtp_pkg::DEPTH_W-1:0] in_write_depth,
  input  logic [shtp_pkg::PAYLOAD_W-1:0]      in_write_payload,
  output logic                                out_strobe,
  output logic                                out_hit,
  output logic [shtp_pkg::WAY_FIELD_W-1:0]    out_chosen_way,
  output logic                                out_way_was_empty,
  output logic signed [shtp_pkg::DEPTH_W-1:0] out_entry_depth,
  output logic [shtp_pkg::PAYLOAD_W-1:0]      out_entry_payload,
  output logic [shtp_pkg::COUNT_W-1:0]        out_used_count
);

  localparam int CIW   = $clog2(CLUSTERS);
  localparam int WIW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NROWS = (shtp_pkg::SAMPLE_TOTAL / WAYS < CLUSTERS) ?
                         shtp_pkg::SAMPLE_TOTAL / WAYS : CLUSTERS;
  localparam int SAW   = $clog2(NROWS + 1);
  localparam int RCW   = $clog2(WAYS + 1);
  localparam int OWW   = shtp_pkg::WAY_FIELD_W;
  localparam int CNW   = shtp_pkg::COUNT_W;
  localparam int TW    = shtp_pkg::TAG_W;
  localparam int KW    = shtp_pkg::KEY_W;

  typedef shtp_pkg::entry_t [WAYS-1:0] row_t;

  row_t mem [CLUSTERS];

  // Captured item
  logic [shtp_pkg::CMD_W-1:0]          cmd_r;
  logic [TW-1:0]                       tag_r;
  logic [CIW-1:0]                      idx_r;
  logic [shtp_pkg::WAY_FIELD_W-1:0]    wway_r;
  logic signed [shtp_pkg::DEPTH_W-1:0] wdepth_r;
  logic [shtp_pkg::PAYLOAD_W-1:0]      wpayload_r;

  row_t           rd_row_r;
  logic           rd_en;
  logic [CIW-1:0] rd_addr;

  logic [CIW-1:0] clr_addr_r;
  logic [SAW-1:0] scan_addr_r;
  logic           scan_vld_r;
  logic [CNW-1:0] acc_r;
  logic           scan_issue;
  logic [RCW-1:0] row_cnt;

  logic [WAYS-1:0] way_empty, way_match;
  logic            found;
  logic [WIW-1:0]  first_way, best_way;
  logic signed [shtp_pkg::DEPTH_W-1:0] best_depth;
  logic            is_probe, is_write, way_ok, hit;
  logic [WIW-1:0]  wway_idx;
  row_t            row_wr;
  logic            mem_we;
  logic [CIW-1:0]  mem_wa;
  row_t            mem_wd;

  logic                                out_strobe_r, out_hit_r, out_empty_r;
  logic [OWW-1:0]                      out_way_r;
  logic signed [shtp_pkg::DEPTH_W-1:0] out_depth_r;
  logic [shtp_pkg::PAYLOAD_W-1:0]      out_payload_r;
  logic [CNW-1:0]                      out_count_r;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r      <= in_command;
      tag_r      <= in_key[KW-1:KW-TW];
      idx_r      <= in_key[CIW-1:0];
      wway_r     <= in_write_way;
      wdepth_r   <= in_write_depth;
      wpayload_r <= in_write_payload;
    end
  end

  // Read port: the item's cluster on capture, else the next scan row
  assign scan_issue = ctl.scan_run && (scan_addr_r != SAW'(NROWS));
  assign rd_en      = ctl.capture || scan_issue;
  assign rd_addr    = ctl.capture ? in_key[CIW-1:0] : CIW'(scan_addr_r);

  always_ff @(posedge clk) begin
    if (rd_en) rd_row_r <= mem[rd_addr];
  end

  always_comb begin
    found      = 1'b0;
    first_way  = '0;
    best_way   = '0;
    best_depth = rd_row_r[0].depth;
    for (int w = 0; w < WAYS; w++) begin
      way_empty[w] = (rd_row_r[w].tag == '0);
      way_match[w] = (rd_row_r[w].tag == tag_r);
      if (!found && (way_empty[w] || way_match[w])) begin
        found     = 1'b1;
        first_way = WIW'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (best_depth > rd_row_r[w].depth) begin
        best_depth = rd_row_r[w].depth;
        best_way   = WIW'(w);
      end
    end
  end

  assign is_probe = (cmd_r == shtp_pkg::CMD_PROBE);
  assign is_write = (cmd_r == shtp_pkg::CMD_WRITE);
  assign way_ok   = (int'(wway_r) < WAYS);
  assign wway_idx = WIW'(wway_r);
  assign hit      = is_probe && found && !way_empty[first_way];

  always_comb begin
    row_wr = rd_row_r;
    if (hit) row_wr[first_way].gen = gen;
    if (is_write && way_ok) begin
      row_wr[wway_idx].tag     = tag_r;
      row_wr[wway_idx].depth   = wdepth_r;
      row_wr[wway_idx].gen     = gen;
      row_wr[wway_idx].payload = wpayload_r;
    end
  end

  // Write port: clearing pass, hit refresh or entry write
  assign mem_we = ctl.clear_step || (ctl.eval && (hit || (is_write && way_ok)));
  assign mem_wa = ctl.clear_step ? clr_addr_r : idx_r;
  assign mem_wd = ctl.clear_step ? row_t'('0) : row_wr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (ctl.clear_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_comb begin
    row_cnt = '0;
    for (int w = 0; w < WAYS; w++) begin
      row_cnt = row_cnt + RCW'(rd_row_r[w].gen == gen);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      scan_vld_r  <= 1'b0;
      acc_r       <= '0;
    end else if (ctl.capture) begin
      scan_addr_r <= '0;
      scan_vld_r  <= 1'b0;
      acc_r       <= '0;
    end else if (ctl.scan_run) begin
      scan_vld_r <= scan_issue;
      if (scan_issue) scan_addr_r <= scan_addr_r + 1'b1;
      if (scan_vld_r) acc_r <= acc_r + CNW'(row_cnt);
    end
  end

  assign sts.clear_last = (clr_addr_r == CIW'(CLUSTERS - 1));
  assign sts.scan_done  = (scan_addr_r == SAW'(NROWS)) && !scan_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl.eval || ctl.scan_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval || ctl.scan_emit) begin
      out_hit_r     <= ctl.eval && hit;
      out_way_r     <= (ctl.eval && is_probe) ? OWW'(found ? first_way : best_way) : '0;
      out_empty_r   <= ctl.eval && is_probe && found && way_empty[first_way];
      out_depth_r   <= (ctl.eval && hit) ? rd_row_r[first_way].depth : '0;
      out_payload_r <= (ctl.eval && hit) ? rd_row_r[first_way].payload : '0;
      out_count_r   <= ctl.scan_emit ? acc_r : '0;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_hit           = out_hit_r;
  assign out_chosen_way    = out_way_r;
  assign out_way_was_empty = out_empty_r;
  assign out_entry_depth   = out_depth_r;
  assign out_entry_payload = out_payload_r;
  assign out_used_count    = out_count_r;

endmodule

>>> rtl/set_assoc_hash_table_probe.sv
// Probe, write and unused command: the beat is captured with its cluster row, evaluated in
// S_EVAL and returned on out_strobe; the next beat can be accepted while out_strobe is high.
// Fullness: reads min(1000/WAYS, CLUSTERS) cluster rows, one cluster row read a cycle; the
// next beat can be accepted while out_strobe is high.
// Reset (rst_n low, synchronous) starts a clearing pass over all CLUSTERS rows, one row a cycle;
// busy stays high until it ends. Results cannot be stalled. Depends on shtp_pkg, shtp_ctrl,
// shtp_dp and set_assoc_hash_table_probe_defines.svh.
`include "set_assoc_hash_table_probe_defines.svh"

module set_assoc_hash_table_probe #(
  parameter int WAYS     = shtp_pkg::WAYS_DEF,
  // Cluster index is the low key bits, so CLUSTERS must be a power of two; the block does not enforce it
  parameter int CLUSTERS = shtp_pkg::CLUSTERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [shtp_pkg::CMD_W-1:0]          in_command,
  input  logic [shtp_pkg::KEY_W-1:0]          in_key,
  input  logic [shtp_pkg::WAY_FIELD_W-1:0]    in_write_way,
  input  logic signed [shtp_pkg::DEPTH_W-1:0] in_write_depth,
  input  logic [shtp_pkg::PAYLOAD_W-1:0]      in_write_payload,
  // Result channel
  output logic                                out_strobe,
  output logic                                out_hit,
  output logic [shtp_pkg::WAY_FIELD_W-1:0]    out_chosen_way,
  output logic                                out_way_was_empty,
  output logic signed [shtp_pkg::DEPTH_W-1:0] out_entry_depth,
  output logic [shtp_pkg::PAYLOAD_W-1:0]      out_entry_payload,
  output logic [shtp_pkg::COUNT_W-1:0]        out_used_count,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [shtp_pkg::APB_AW-1:0]         paddr,
  input  logic [shtp_pkg::APB_DW-1:0]         pwdata,
  output logic [shtp_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int GW = shtp_pkg::GEN_W;

  shtp_pkg::ctl_t ctl;
  shtp_pkg::sts_t sts;

  logic [GW-1:0] gen_r;
  logic          gen_we;

  // Search generation register: hold between writes, take the access beat's data
  assign pready = 1'b1;
  assign gen_we = psel && penable && pwrite && pready && (paddr == shtp_pkg::ADDR_GEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= '0;
    end else if (gen_we) begin
      gen_r <= pwdata[GW-1:0];
    end
  end

  assign prdata = (paddr == shtp_pkg::ADDR_GEN) ?
                  {{(shtp_pkg::APB_DW - GW){1'b0}}, gen_r} : '0;

  // Sequencer: clearing pass, then one command at a time
  shtp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .ctl        (ctl),
    .busy       (busy)
  );

  // Memory, compare, replacement pick and fullness accumulation
  shtp_dp #(
    .WAYS     (WAYS),
    .CLUSTERS (CLUSTERS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .gen               (gen_r),
    .in_command        (in_command),
    .in_key            (in_key),
    .in_write_way      (in_write_way),
    .in_write_depth    (in_write_depth),
    .in_write_payload  (in_write_payload),
    .out_strobe        (out_strobe),
    .out_hit           (out_hit),
    .out_chosen_way    (out_chosen_way),
    .out_way_was_empty (out_way_was_empty),
    .out_entry_depth   (out_entry_depth),
    .out_entry_payload (out_entry_payload),
    .out_used_count    (out_used_count)
  );

  // An accepted beat always makes the block busy on the next cycle
  `SHTP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result only comes out of a busy cycle
  `SHTP_ASSERT_SAME(a_strobe_after_busy, out_strobe, $past(busy))
  // Two results never come out in adjacent cycles
  `SHTP_ASSERT_NEXT(a_strobe_spacing, out_strobe, !out_strobe)
  // A hit never reports an empty way
  `SHTP_ASSERT_SAME(a_hit_not_empty, out_strobe && out_hit, !out_way_was_empty)

endmodule
